// ----- src/iab_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iab_pkg: shared types and codes for the indexed array bag engine
// Item and result payloads, action and status codes, and the command and
// status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package iab_pkg;

    // input item and result payloads
    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  index;
        logic [7:0]  second_index;
        logic [63:0] value;
    } t_item;

    typedef struct packed {
        logic [63:0] read_value;
        logic        found;
        logic [1:0]  status;
        logic [8:0]  fill_count;
    } t_result;

    // action codes
    localparam logic [2:0] ACT_APPEND    = 3'd0;
    localparam logic [2:0] ACT_READ      = 3'd1;
    localparam logic [2:0] ACT_OVERWRITE = 3'd2;
    localparam logic [2:0] ACT_SWAP      = 3'd3;
    localparam logic [2:0] ACT_REM_IDX   = 3'd4;
    localparam logic [2:0] ACT_CONTAINS  = 3'd5;
    localparam logic [2:0] ACT_REM_VAL   = 3'd6;
    localparam logic [2:0] ACT_UNUSED    = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // memory read address select
    localparam logic [2:0] RD_IDX  = 3'd0;
    localparam logic [2:0] RD_IDX2 = 3'd1;
    localparam logic [2:0] RD_PTR  = 3'd2;
    localparam logic [2:0] RD_PTR1 = 3'd3;
    localparam logic [2:0] RD_PTR2 = 3'd4;

    // memory write address select
    localparam logic [1:0] WA_CNT  = 2'd0;
    localparam logic [1:0] WA_IDX  = 2'd1;
    localparam logic [1:0] WA_IDX2 = 2'd2;
    localparam logic [1:0] WA_PTR  = 2'd3;

    // memory write data select
    localparam logic [1:0] WD_VALUE = 2'd0;
    localparam logic [1:0] WD_RDATA = 2'd1;
    localparam logic [1:0] WD_TMP   = 2'd2;

    // pointer operations
    localparam logic [2:0] PTR_HOLD = 3'd0;
    localparam logic [2:0] PTR_ZERO = 3'd1;
    localparam logic [2:0] PTR_IDX  = 3'd2;
    localparam logic [2:0] PTR_HIT  = 3'd3;
    localparam logic [2:0] PTR_INC  = 3'd4;
    localparam logic [2:0] PTR_SCAN = 3'd5;

    // fill count operations
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;

    typedef struct packed {
        logic       load;
        logic [2:0] rd_sel;
        logic       wr_en;
        logic [1:0] wa_sel;
        logic [1:0] wd_sel;
        logic       tmp_load;
        logic [2:0] ptr_op;
        logic [1:0] cnt_op;
        logic       res_status_en;
        logic [1:0] res_status;
        logic       res_found;
        logic       res_cap;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic       empty;
        logic       full;
        logic       idx_bad;
        logic       idx2_bad;
        logic       match;
        logic       issue;
        logic       more1;
        logic       more2;
    } t_dp_stat;

endpackage
`default_nettype wire

// ----- src/iab_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iab_dp: datapath of the indexed array bag engine
// Entry memory, fill count, walk pointer, compare stage and result registers.
// ----------------------------------------------------------------------------
module iab_dp #(
    parameter int DEPTH = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire iab_pkg::t_item   i_item,
    input  wire iab_pkg::t_dp_cmd i_cmd,
    output iab_pkg::t_dp_stat     o_stat,
    output iab_pkg::t_result      o_result
);
    import iab_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 8) ? CW : 8;

    logic [63:0]   r_mem [DEPTH];
    logic [63:0]   r_rdata;
    logic [63:0]   r_tmp;
    t_item         r_item;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_ptr;
    logic [CW-1:0] n_ptr;
    logic [CW-1:0] r_cmp_pos;
    logic          r_cmp_vld;
    logic [63:0]   r_read_value;
    logic          r_found;
    logic [1:0]    r_status;

    logic [CW-1:0] ptr_p1;
    logic [CW-1:0] ptr_p2;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;
    logic          issue;

    assign ptr_p1 = r_ptr + CW'(1);
    assign ptr_p2 = r_ptr + CW'(2);
    assign issue  = (r_ptr < r_count);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_IDX:  rd_addr = AW'(r_item.index);
            RD_IDX2: rd_addr = AW'(r_item.second_index);
            RD_PTR:  rd_addr = r_ptr[AW-1:0];
            RD_PTR1: rd_addr = ptr_p1[AW-1:0];
            RD_PTR2: rd_addr = ptr_p2[AW-1:0];
            default: rd_addr = r_ptr[AW-1:0];
        endcase
    end

    always_comb begin
        case (i_cmd.wa_sel)
            WA_CNT:  wr_addr = r_count[AW-1:0];
            WA_IDX:  wr_addr = AW'(r_item.index);
            WA_IDX2: wr_addr = AW'(r_item.second_index);
            WA_PTR:  wr_addr = r_ptr[AW-1:0];
            default: wr_addr = r_ptr[AW-1:0];
        endcase
    end

    always_comb begin
        case (i_cmd.wd_sel)
            WD_VALUE: wr_data = r_item.value;
            WD_RDATA: wr_data = r_rdata;
            WD_TMP:   wr_data = r_tmp;
            default:  wr_data = r_item.value;
        endcase
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_comb begin
        case (i_cmd.ptr_op)
            PTR_ZERO: n_ptr = '0;
            PTR_IDX:  n_ptr = CW'(r_item.index);
            PTR_HIT:  n_ptr = r_cmp_pos;
            PTR_INC:  n_ptr = ptr_p1;
            PTR_SCAN: n_ptr = issue ? ptr_p1 : r_ptr;
            default:  n_ptr = r_ptr;
        endcase
    end

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_INC: n_count = r_count + CW'(1);
            CNT_DEC: n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ptr     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ptr   <= n_ptr;
            if (i_cmd.load) begin
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.ptr_op == PTR_SCAN) begin
                r_cmp_vld <= issue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.tmp_load) begin
            r_tmp <= r_rdata;
        end
        if (i_cmd.ptr_op == PTR_SCAN) begin
            r_cmp_pos <= r_ptr;
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_read_value <= '0;
            r_found      <= 1'b0;
            r_status     <= ST_OK;
        end else begin
            if (i_cmd.res_cap) begin
                r_read_value <= r_rdata;
            end
            if (i_cmd.res_found) begin
                r_found <= 1'b1;
            end
            if (i_cmd.res_status_en) begin
                r_status <= i_cmd.res_status;
            end
        end
    end

    always_comb begin
        o_stat.action   = r_item.action;
        o_stat.empty    = (r_count == '0);
        o_stat.full     = (r_count == CW'(DEPTH));
        o_stat.idx_bad  = (XW'(r_item.index) >= XW'(r_count));
        o_stat.idx2_bad = (XW'(r_item.second_index) >= XW'(r_count));
        o_stat.match    = r_cmp_vld && (r_rdata == r_item.value);
        o_stat.issue    = issue;
        o_stat.more1    = ((CW + 1)'(r_ptr) + (CW + 1)'(1)) < (CW + 1)'(r_count);
        o_stat.more2    = ((CW + 1)'(r_ptr) + (CW + 1)'(2)) < (CW + 1)'(r_count);
    end

    always_comb begin
        o_result.read_value = r_read_value;
        o_result.found      = r_found;
        o_result.status     = r_status;
        o_result.fill_count = 9'(r_count);
    end

endmodule
`default_nettype wire

// ----- src/iab_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iab_ctrl: controller of the indexed array bag engine
// Decodes the action and sequences reads, writes, scans and gap closing.
// ----------------------------------------------------------------------------
module iab_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire iab_pkg::t_dp_stat i_stat,
    output logic                   busy,
    output logic                   o_done,
    output iab_pkg::t_dp_cmd       o_cmd
);
    import iab_pkg::*;

    localparam logic [3:0] S_IDLE        = 4'd0;
    localparam logic [3:0] S_DECODE      = 4'd1;
    localparam logic [3:0] S_RD_WAIT     = 4'd2;
    localparam logic [3:0] S_SWAP_A      = 4'd3;
    localparam logic [3:0] S_SWAP_B      = 4'd4;
    localparam logic [3:0] S_SWAP_W2     = 4'd5;
    localparam logic [3:0] S_SCAN        = 4'd6;
    localparam logic [3:0] S_SHIFT_PRIME = 4'd7;
    localparam logic [3:0] S_SHIFT       = 4'd8;
    localparam logic [3:0] S_FINISH      = 4'd9;
    localparam logic [3:0] S_DONE        = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                if (i_stat.action == ACT_APPEND) begin
                    if (i_stat.full) begin
                        o_cmd.res_status_en = 1'b1;
                        o_cmd.res_status    = ST_FULL;
                    end else begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wa_sel = WA_CNT;
                        o_cmd.wd_sel = WD_VALUE;
                        o_cmd.cnt_op = CNT_INC;
                    end
                end else if (i_stat.action == ACT_UNUSED) begin
                    // unused action code: plain ok result
                    n_state = S_DONE;
                end else if (i_stat.empty) begin
                    o_cmd.res_status_en = 1'b1;
                    o_cmd.res_status    = ST_EMPTY;
                end else if (i_stat.action == ACT_CONTAINS ||
                             i_stat.action == ACT_REM_VAL) begin
                    o_cmd.ptr_op = PTR_ZERO;
                    n_state      = S_SCAN;
                end else if (i_stat.idx_bad ||
                             (i_stat.action == ACT_SWAP && i_stat.idx2_bad)) begin
                    o_cmd.res_status_en = 1'b1;
                    o_cmd.res_status    = ST_RANGE;
                end else begin
                    case (i_stat.action)
                        ACT_READ: begin
                            o_cmd.rd_sel = RD_IDX;
                            n_state      = S_RD_WAIT;
                        end
                        ACT_OVERWRITE: begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wa_sel = WA_IDX;
                            o_cmd.wd_sel = WD_VALUE;
                        end
                        ACT_SWAP: begin
                            o_cmd.rd_sel = RD_IDX;
                            n_state      = S_SWAP_A;
                        end
                        ACT_REM_IDX: begin
                            o_cmd.ptr_op = PTR_IDX;
                            n_state      = S_SHIFT_PRIME;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RD_WAIT: begin
                o_cmd.res_cap = 1'b1;
                n_state       = S_DONE;
            end
            S_SWAP_A: begin
                // first entry arrives, keep it and fetch the second
                o_cmd.tmp_load = 1'b1;
                o_cmd.rd_sel   = RD_IDX2;
                n_state        = S_SWAP_B;
            end
            S_SWAP_B: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wa_sel = WA_IDX;
                o_cmd.wd_sel = WD_RDATA;
                n_state      = S_SWAP_W2;
            end
            S_SWAP_W2: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wa_sel = WA_IDX2;
                o_cmd.wd_sel = WD_TMP;
                n_state      = S_DONE;
            end
            S_SCAN: begin
                if (i_stat.match) begin
                    o_cmd.res_found = 1'b1;
                    if (i_stat.action == ACT_REM_VAL) begin
                        o_cmd.ptr_op = PTR_HIT;
                        n_state      = S_SHIFT_PRIME;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (!i_stat.issue) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_sel = RD_PTR;
                    o_cmd.ptr_op = PTR_SCAN;
                end
            end
            S_SHIFT_PRIME: begin
                if (i_stat.more1) begin
                    o_cmd.rd_sel = RD_PTR1;
                    n_state      = S_SHIFT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SHIFT: begin
                // move the next entry down one place, fetch the one after it
                o_cmd.wr_en  = 1'b1;
                o_cmd.wa_sel = WA_PTR;
                o_cmd.wd_sel = WD_RDATA;
                o_cmd.rd_sel = RD_PTR2;
                o_cmd.ptr_op = PTR_INC;
                if (!i_stat.more2) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.cnt_op = CNT_DEC;
                n_state      = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- src/indexed_array_bag_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_array_bag_engine: fixed-capacity array list and bag of 64-bit words
// Append, read, overwrite, swap, remove at index, contains and remove value
// on a DEPTH-entry memory with a fill count.
//
// usage
//   - an item transfers on a rising edge with start high and busy low; busy
//     stays high until the result has been shown
//   - every item gives one result on o_result, held for exactly one cycle
//     with o_done high; the receiver has no way to hold it off
//   - append, overwrite, unused codes and error cases go from decode straight
//     to o_done; read adds a registered read; swap two reads and two writes
//   - remove at index p moves each later entry down one place, one entry moved per
//     cycle through the single write port and registered read port
//   - contains and remove value scan one entry per cycle with the compare
//     in the cycle after its read; the scan stops at the first hit, and a
//     hit at position p for remove value adds the gap closing from p
//   - one item at a time; the next transfer is possible the cycle after o_done
//   - reset clears the fill count and the controller; memory contents are
//     not cleared since only entries below the fill count are ever read
// ----------------------------------------------------------------------------
module indexed_array_bag_engine #(
    parameter int DEPTH = 256
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire iab_pkg::t_item  i_item,
    output logic                 busy,
    output logic                 o_done,
    output iab_pkg::t_result     o_result
);
    import iab_pkg::*;

    // command and status between controller and datapath
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: decode, scan, shift and result timing
    iab_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (dp_stat),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (dp_cmd)
    );

    // entry memory, fill count, walk pointer and result registers
    iab_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

// ----- bench/indexed_array_bag_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_bag_checker: result predictor and scoreboard
// Watches the item and result channels of the array bag engine, keeps its own
// copy of the entry array and fill count, and compares every result against
// the oldest prediction.
// ----------------------------------------------------------------------------
module indexed_array_bag_checker
    import iab_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  t_item      i_item,
    input  logic       i_done,
    input  t_result    i_result,
    output int         o_pending,
    output logic [8:0] o_fill_count,
    output int         o_fail_count
);

    logic [63:0] entries [DEPTH];
    logic [8:0]  entry_total;
    t_result     expected_q [$];
    int          fail_count;

    // shift later entries down over position pos
    function automatic void close_gap(int pos);
        for (int k = pos; k + 1 < entry_total; k++) begin
            entries[k] = entries[k + 1];
        end
        entry_total = entry_total - 9'd1;
    endfunction

    function automatic t_result apply_action(t_item it);
        t_result     res;
        int          hit;
        logic [63:0] held;
        res = '0;
        hit = -1;
        case (it.action)
            ACT_APPEND: begin
                if (entry_total >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    entries[entry_total] = it.value;
                    entry_total = entry_total + 9'd1;
                end
            end
            ACT_CONTAINS, ACT_REM_VAL: begin
                if (entry_total == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    for (int k = 0; k < entry_total && hit < 0; k++) begin
                        if (entries[k] == it.value) hit = k;
                    end
                    res.found = (hit >= 0);
                    if (hit >= 0 && it.action == ACT_REM_VAL) close_gap(hit);
                end
            end
            ACT_READ, ACT_OVERWRITE, ACT_SWAP, ACT_REM_IDX: begin
                if (entry_total == 0) begin
                    res.status = ST_EMPTY;
                end else if (it.index >= entry_total ||
                             (it.action == ACT_SWAP && it.second_index >= entry_total)) begin
                    res.status = ST_RANGE;
                end else begin
                    case (it.action)
                        ACT_READ:      res.read_value = entries[it.index];
                        ACT_OVERWRITE: entries[it.index] = it.value;
                        ACT_SWAP: begin
                            held = entries[it.index];
                            entries[it.index] = entries[it.second_index];
                            entries[it.second_index] = held;
                        end
                        default:       close_gap(it.index);
                    endcase
                end
            end
            default: ;  // unused code leaves everything alone
        endcase
        res.fill_count = entry_total;
        return res;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s: expected %h, actual %h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            entry_total = '0;
            expected_q.delete();
            fail_count = 0;
        end else begin
            // results first: a transfer on the same edge belongs to a newer item
            if (i_done) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    $error("result with no pending item: %p", i_result);
                end else begin
                    want = expected_q.pop_front();
                    check_field("read_value", want.read_value, i_result.read_value);
                    check_field("found", 64'(want.found), 64'(i_result.found));
                    check_field("status", 64'(want.status), 64'(i_result.status));
                    check_field("fill_count", 64'(want.fill_count), 64'(i_result.fill_count));
                end
            end
            if (i_start && !i_busy) begin
                expected_q.push_back(apply_action(i_item));
            end
        end
        o_pending    <= expected_q.size();
        o_fill_count <= entry_total;
        o_fail_count <= fail_count;
    end

endmodule

// ----- bench/indexed_array_bag_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_bag_engine_tb: top level of the array bag engine bench
// Drives a directed opening, a fill to capacity and a long random run of
// append, read, overwrite, swap, remove and search commands with random
// idle gaps; the checker beside the engine predicts and compares results.
// ----------------------------------------------------------------------------
module indexed_array_bag_engine_tb;
    import iab_pkg::*;

    localparam int         DEPTH       = 256;
    localparam int         TOTAL_ITEMS = 1300;
    localparam int         CYCLE_LIMIT = 4_000_000;
    localparam int         POOL_SIZE   = 16;

    // stimulus mood of one random chunk
    typedef enum logic [1:0] {
        PROF_GROW,
        PROF_MIX,
        PROF_SHRINK
    } t_profile;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    t_item      i_item;
    logic       busy;
    logic       o_done;
    t_result    o_result;

    int         pending;
    logic [8:0] fill_hint;
    int         fail_count;
    int         items_sent;
    int         cycle_count;

    // small set of words shared by appends and searches so that hits and
    // duplicates are common
    logic [63:0] value_pool [POOL_SIZE];

    indexed_array_bag_engine #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    indexed_array_bag_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_item      (i_item),
        .i_done      (o_done),
        .i_result    (o_result),
        .o_pending   (pending),
        .o_fill_count(fill_hint),
        .o_fail_count(fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: a hung engine or a lost result ends here
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_item mk(logic [2:0] act, logic [7:0] idx, logic [7:0] idx2,
                                 logic [63:0] val);
        t_item it;
        it.action       = act;
        it.index        = idx;
        it.second_index = idx2;
        it.value        = val;
        return it;
    endfunction

    function automatic logic [63:0] pick_value(int pool_pct);
        if ($urandom_range(99) < pool_pct) return value_pool[$urandom_range(POOL_SIZE - 1)];
        return {$urandom, $urandom};
    endfunction

    // mostly in range, now and then anywhere in the 8-bit space
    function automatic logic [7:0] pick_index(logic [8:0] fill);
        if (fill == 0 || $urandom_range(99) < 12) return 8'($urandom_range(255));
        return 8'($urandom_range(int'(fill) - 1));
    endfunction

    // mostly back to back, some short gaps, a few long ones that can outlast
    // even a full memory walk
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(4, 1);
        if (r < 98) return $urandom_range(40, 5);
        return $urandom_range(300, 41);
    endfunction

    function automatic t_item random_item(t_profile prof, logic [8:0] fill);
        t_item it;
        int    r;
        int    append_pct;
        int    remove_pct;
        case (prof)
            PROF_GROW: begin
                append_pct = 55;
                remove_pct = 8;
            end
            PROF_MIX: begin
                append_pct = 25;
                remove_pct = 20;
            end
            default: begin
                append_pct = 8;
                remove_pct = 50;
            end
        endcase
        it = mk(ACT_APPEND, pick_index(fill), pick_index(fill), pick_value(60));
        r  = $urandom_range(99);
        if (r < 2) begin
            it.action = ACT_UNUSED;
        end else if (r < 2 + append_pct) begin
            it.action = ACT_APPEND;
        end else if (r < 2 + append_pct + remove_pct) begin
            it.action = $urandom_range(1) ? ACT_REM_IDX : ACT_REM_VAL;
        end else begin
            case ($urandom_range(3))
                0:       it.action = ACT_READ;
                1:       it.action = ACT_OVERWRITE;
                2:       it.action = ACT_SWAP;
                default: it.action = ACT_CONTAINS;
            endcase
        end
        // searches lean harder on the pool so they hit most of the time
        if (it.action == ACT_CONTAINS || it.action == ACT_REM_VAL) begin
            it.value = pick_value(80);
        end
        return it;
    endfunction

    // one command transfer; start stays high across back-to-back items
    task automatic send(t_item it, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    // hold the sender until every pending result has come back
    task automatic wait_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_profile prof;
        int       chunk_len;
        bit       calm;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        items_sent = 0;
        value_pool[0] = 64'h0;
        value_pool[1] = '1;
        value_pool[2] = 64'h1;
        value_pool[3] = 64'h8000_0000_0000_0000;
        value_pool[4] = 64'h7FFF_FFFF_FFFF_FFFF;
        for (int k = 5; k < POOL_SIZE; k++) value_pool[k] = {$urandom, $urandom};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every indexed and search action on an empty array
        send(mk(ACT_READ, 8'd0, 8'd0, 64'h0), pick_gap());
        send(mk(ACT_OVERWRITE, 8'd0, 8'd0, '1), pick_gap());
        send(mk(ACT_SWAP, 8'd0, 8'd0, 64'h0), pick_gap());
        send(mk(ACT_REM_IDX, 8'd0, 8'd0, 64'h0), pick_gap());
        send(mk(ACT_CONTAINS, 8'd0, 8'd0, 64'h0), pick_gap());
        send(mk(ACT_REM_VAL, 8'd0, 8'd0, 64'h0), pick_gap());
        send(mk(ACT_UNUSED, 8'd0, 8'd0, 64'h0), pick_gap());

        // extreme words and a duplicate
        send(mk(ACT_APPEND, 8'd0, 8'd0, 64'h0), pick_gap());
        send(mk(ACT_APPEND, 8'd0, 8'd0, '1), pick_gap());
        send(mk(ACT_APPEND, 8'd0, 8'd0, 64'h8000_0000_0000_0000), pick_gap());
        send(mk(ACT_APPEND, 8'd0, 8'd0, '1), pick_gap());
        send(mk(ACT_APPEND, 8'd0, 8'd0, 64'h0123_4567_89AB_CDEF), pick_gap());

        // reads at both ends and just past them
        send(mk(ACT_READ, 8'd4, 8'd0, 64'h0), pick_gap());
        send(mk(ACT_READ, 8'd0, 8'd0, 64'h0), pick_gap());
        send(mk(ACT_READ, 8'd5, 8'd0, 64'h0), pick_gap());
        send(mk(ACT_READ, 8'd255, 8'd0, 64'h0), pick_gap());

        // overwrite, swap, and swap with either index out of range
        send(mk(ACT_OVERWRITE, 8'd2, 8'd0, 64'h5555_5555_5555_5555), pick_gap());
        send(mk(ACT_SWAP, 8'd0, 8'd4, 64'h0), pick_gap());
        send(mk(ACT_SWAP, 8'd1, 8'd200, 64'h0), pick_gap());
        send(mk(ACT_SWAP, 8'd255, 8'd0, 64'h0), pick_gap());

        // search hit and miss; value removal takes only the first duplicate
        send(mk(ACT_CONTAINS, 8'd0, 8'd0, '1), pick_gap());
        send(mk(ACT_CONTAINS, 8'd0, 8'd0, 64'h1), pick_gap());
        send(mk(ACT_REM_VAL, 8'd0, 8'd0, '1), pick_gap());
        send(mk(ACT_CONTAINS, 8'd0, 8'd0, '1), pick_gap());
        send(mk(ACT_REM_VAL, 8'd0, 8'd0, 64'h1), pick_gap());

        // remove from the head, the tail, and past the tail
        send(mk(ACT_REM_IDX, 8'd0, 8'd0, 64'h0), pick_gap());
        send(mk(ACT_REM_IDX, 8'd2, 8'd0, 64'h0), pick_gap());
        send(mk(ACT_REM_IDX, 8'd2, 8'd0, 64'h0), pick_gap());
        send(mk(ACT_UNUSED, 8'hFF, 8'hFF, '1), pick_gap());
        wait_drain();

        // fill to capacity, then appends that must bounce off a full array
        while (fill_hint < DEPTH) send(mk(ACT_APPEND, 8'd0, 8'd0, pick_value(60)), pick_gap());
        repeat (3) send(mk(ACT_APPEND, 8'd0, 8'd0, pick_value(60)), pick_gap());
        send(mk(ACT_READ, 8'd255, 8'd0, 64'h0), pick_gap());
        send(mk(ACT_SWAP, 8'd0, 8'd255, 64'h0), pick_gap());
        send(mk(ACT_OVERWRITE, 8'd255, 8'd0, '1), pick_gap());
        send(mk(ACT_REM_IDX, 8'd0, 8'd0, 64'h0), pick_gap());

        // random chunks; the profile walks the fill level up and down so
        // both the empty and the full corners come back
        while (items_sent < TOTAL_ITEMS) begin
            prof      = t_profile'($urandom_range(2));
            chunk_len = $urandom_range(80, 30);
            calm      = ($urandom_range(3) == 0);
            for (int n = 0; n < chunk_len && items_sent < TOTAL_ITEMS; n++) begin
                send(random_item(prof, fill_hint), calm ? 0 : pick_gap());
            end
            if ($urandom_range(3) == 0) wait_drain();
        end

        // let the last results arrive, then a margin for anything stray
        wait_drain();
        repeat (DEPTH + 20) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
